// ----- rtl/ctrwr_pkg.sv -----
// Package for the color table range-write block.
// Holds default sizes, field widths, status codes and the sequencer state type.
package ctrwr_pkg;

	localparam int TABLE_DEPTH_DEF    = 512;
	localparam int COMPONENT_BITS_DEF = 16;

	localparam int BOUND_W = 10;
	localparam int RIDX_W  = 9;
	localparam int COLOR_W = 16;
	localparam int WIDTH_W = 10;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ORDER  = 2'd1;
	localparam logic [1:0] ST_BOUNDS = 2'd2;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RD_WAIT,
		S_WRITE,
		S_RAMP_INIT,
		S_RAMP_CHECK,
		S_RAMP_WAIT,
		S_MUL1,
		S_MUL2,
		S_DIV,
		S_RAMP_WR,
		S_FINISH
	} state_t;

endpackage

// ----- rtl/ctrwr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the color table storage.
module ctrwr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/color_table_range_write_with_ramps_core.sv -----
// Color table with range writes and linear edge ramps, top level.
// Depends on ctrwr_pkg and ctrwr_ram.
//
// channel   dir  handshake          payload
// s_axis    in   tvalid/tready      tuser: kind; tdata: bounds, read index, color
// m_axis    out  tvalid/tready      tlast: run_done; tdata: status, color
// cfg       in   cfg_we             cfg_wdata: smoothing_width
//
// Items are taken only while idle; reads, entry writes and rejected items each return one
// result. The last entry of a run adds ramps: none with zero width, else up to 2*width
// ramped entries, each computed by the shared multiply/divide unit. After reset a clearing
// pass over all TABLE_DEPTH entries fills the table; no item is taken meanwhile. Input waits
// while a result is held and not taken.
module color_table_range_write_with_ramps_core #(
	parameter int TABLE_DEPTH    = ctrwr_pkg::TABLE_DEPTH_DEF,
	parameter int COMPONENT_BITS = ctrwr_pkg::COMPONENT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// range_start[9:0] range_end[19:10] read_index[28:20] red_in[44:29]
	// green_in[60:45] blue_in[76:61] alpha_in[92:77], zero fill
	input  logic [95:0] s_tdata,
	// kind[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0] red_out[17:2] green_out[33:18] blue_out[49:34] alpha_out[65:50]
	output logic [71:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int XW  = (AW + 2 > 12) ? AW + 2 : 12;
	localparam int CB  = COMPONENT_BITS;
	localparam int NW  = CB + 11;
	localparam int DCW = $clog2(CB);
	localparam int EW  = 4 * CB;
	localparam logic [XW-1:0] DEPTH_X = XW'(TABLE_DEPTH);
	localparam logic [CB-1:0] CMAX    = {CB{1'b1}};
	localparam logic [EW-1:0] RST_ENTRY = {CMAX, {CB{1'b0}}, {CB{1'b0}}, CMAX};

	ctrwr_pkg::state_t state_q, state_d;

	logic [9:0]    width_q;
	logic [9:0]    start_q, end_q;
	logic [EW-1:0] color_q, edge_q;
	logic [XW-1:0] ew_q;
	logic [XW-1:0] i_q, limit_q;
	logic          side_q;
	logic [9:0]    k_q;
	logic [1:0]    c_q;
	logic [NW-1:0] acc_q, den_q;
	logic [CB-1:0] quo_q;
	logic [DCW-1:0] dc_q;
	logic [CB-1:0] new_q [4];

	logic          m_valid_q, m_last_q, m_load;
	logic [1:0]    status_q;
	logic [15:0]   red_q, green_q, blue_q, alpha_q;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, rd_data;

	// input fields
	logic [9:0]    in_start, in_end;
	logic [8:0]    in_ridx;
	logic [EW-1:0] in_color;
	logic          accept, in_read_ok, in_write_ok;

	assign in_start = s_tdata[9:0];
	assign in_end   = s_tdata[19:10];
	assign in_ridx  = s_tdata[28:20];
	assign in_color = {s_tdata[77 +: CB], s_tdata[61 +: CB], s_tdata[45 +: CB],
		s_tdata[29 +: CB]};
	assign accept      = s_tvalid && s_tready;
	assign in_read_ok  = XW'(in_ridx) < DEPTH_X;
	assign in_write_ok = (in_start < in_end) && (XW'(in_end) <= DEPTH_X);

	// write position
	logic [XW-1:0] seq_pos, wr_pos;
	logic          restart, wr_last;
	assign seq_pos = XW'(start_q) + ew_q;
	assign restart = seq_pos >= XW'(end_q);
	assign wr_pos  = restart ? XW'(start_q) : seq_pos;
	assign wr_last = (wr_pos + XW'(1)) >= XW'(end_q);

	// ramp helpers
	logic [XW-1:0] ramp_lo, ramp_hi, end_plus;
	assign ramp_lo  = (XW'(start_q) > XW'(width_q)) ? XW'(start_q) - XW'(width_q) : '0;
	assign end_plus = XW'(end_q) + XW'(width_q);
	assign ramp_hi  = (end_plus > DEPTH_X) ? DEPTH_X : end_plus;

	logic [CB-1:0] old_c, edge_c, op_a, op_b;
	logic [XW-1:0] k_x;
	logic          div_ge, div_bit;
	assign old_c  = rd_data[c_q*CB +: CB];
	assign edge_c = edge_q[c_q*CB +: CB];
	assign op_a   = side_q ? edge_c : old_c;
	assign op_b   = side_q ? old_c : edge_c;
	assign k_x    = side_q ? i_q - XW'(end_q) : i_q + XW'(width_q) - XW'(start_q);
	assign div_ge = acc_q >= den_q;
	assign div_bit = div_ge;

	ctrwr_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctrwr_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ctrwr_pkg::S_CLEAR: begin
				if (i_q == DEPTH_X - XW'(1)) state_d = ctrwr_pkg::S_IDLE;
			end
			ctrwr_pkg::S_IDLE: begin
				if (accept) begin
					if (s_tuser == ctrwr_pkg::KIND_READ) begin
						if (in_read_ok) state_d = ctrwr_pkg::S_RD_WAIT;
					end else if (in_write_ok) begin
						state_d = ctrwr_pkg::S_WRITE;
					end
				end
			end
			ctrwr_pkg::S_RD_WAIT:    state_d = ctrwr_pkg::S_IDLE;
			ctrwr_pkg::S_WRITE: begin
				state_d = wr_last ? ctrwr_pkg::S_RAMP_INIT : ctrwr_pkg::S_IDLE;
			end
			ctrwr_pkg::S_RAMP_INIT: begin
				state_d = (width_q == '0) ? ctrwr_pkg::S_FINISH : ctrwr_pkg::S_RAMP_CHECK;
			end
			ctrwr_pkg::S_RAMP_CHECK: begin
				if (i_q >= limit_q) begin
					if (side_q) state_d = ctrwr_pkg::S_FINISH;
				end else begin
					state_d = ctrwr_pkg::S_RAMP_WAIT;
				end
			end
			ctrwr_pkg::S_RAMP_WAIT:  state_d = ctrwr_pkg::S_MUL1;
			ctrwr_pkg::S_MUL1:       state_d = ctrwr_pkg::S_MUL2;
			ctrwr_pkg::S_MUL2:       state_d = ctrwr_pkg::S_DIV;
			ctrwr_pkg::S_DIV: begin
				if (dc_q == '0) begin
					state_d = (c_q == 2'd3) ? ctrwr_pkg::S_RAMP_WR : ctrwr_pkg::S_MUL1;
				end
			end
			ctrwr_pkg::S_RAMP_WR:    state_d = ctrwr_pkg::S_RAMP_CHECK;
			ctrwr_pkg::S_FINISH:     state_d = ctrwr_pkg::S_IDLE;
			default:                 state_d = ctrwr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		m_load    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = i_q[AW-1:0];
		ram_wdata = RST_ENTRY;
		ram_re    = 1'b0;
		ram_raddr = i_q[AW-1:0];
		case (state_q)
			ctrwr_pkg::S_CLEAR: begin
				ram_we = 1'b1;
			end
			ctrwr_pkg::S_IDLE: begin
				s_tready  = !m_valid_q || m_tready;
				ram_re    = accept && (s_tuser == ctrwr_pkg::KIND_READ) && in_read_ok;
				ram_raddr = AW'(XW'(in_ridx));
				m_load    = accept && ((s_tuser == ctrwr_pkg::KIND_READ) ? !in_read_ok
					: !in_write_ok);
			end
			ctrwr_pkg::S_RD_WAIT: begin
				m_load = 1'b1;
			end
			ctrwr_pkg::S_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = wr_pos[AW-1:0];
				ram_wdata = color_q;
				m_load    = !wr_last;
			end
			ctrwr_pkg::S_RAMP_CHECK: begin
				ram_re = i_q < limit_q;
			end
			ctrwr_pkg::S_RAMP_WR: begin
				ram_we    = 1'b1;
				ram_wdata = {new_q[3], new_q[2], new_q[1], new_q[0]};
			end
			ctrwr_pkg::S_FINISH: begin
				m_load = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
		end else if (cfg_we && (XW'(cfg_wdata) <= DEPTH_X)) begin
			width_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (m_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ew_q      <= '0;
			edge_q    <= '0;
			i_q       <= '0;
			start_q   <= '0;
			end_q     <= '0;
			color_q   <= '0;
			limit_q   <= '0;
			side_q    <= 1'b0;
			k_q       <= '0;
			c_q       <= '0;
			acc_q     <= '0;
			den_q     <= '0;
			quo_q     <= '0;
			dc_q      <= '0;
			new_q     <= '{default: '0};
			m_last_q  <= 1'b0;
			status_q  <= '0;
			{alpha_q, blue_q, green_q, red_q} <= '0;
		end else begin
			case (state_q)
				ctrwr_pkg::S_CLEAR: begin
					i_q <= i_q + XW'(1);
				end
				ctrwr_pkg::S_IDLE: begin
					if (accept) begin
						start_q <= in_start;
						end_q   <= in_end;
						color_q <= in_color;
						if (s_tuser == ctrwr_pkg::KIND_READ) begin
							if (!in_read_ok) begin
								m_last_q  <= 1'b0;
								status_q  <= ctrwr_pkg::ST_BOUNDS;
								{alpha_q, blue_q, green_q, red_q} <= '0;
							end
						end else if (!in_write_ok) begin
							ew_q      <= '0;
							m_last_q  <= 1'b0;
							status_q  <= (in_start >= in_end) ? ctrwr_pkg::ST_ORDER
								: ctrwr_pkg::ST_BOUNDS;
							{alpha_q, blue_q, green_q, red_q} <= '0;
						end
					end
				end
				ctrwr_pkg::S_RD_WAIT: begin
					m_last_q  <= 1'b0;
					status_q  <= ctrwr_pkg::ST_OK;
					red_q     <= 16'(rd_data[0*CB +: CB]);
					green_q   <= 16'(rd_data[1*CB +: CB]);
					blue_q    <= 16'(rd_data[2*CB +: CB]);
					alpha_q   <= 16'(rd_data[3*CB +: CB]);
				end
				ctrwr_pkg::S_WRITE: begin
					if (wr_pos == XW'(start_q)) edge_q <= color_q;
					if (wr_last) begin
						ew_q <= '0;
					end else begin
						ew_q      <= wr_pos - XW'(start_q) + XW'(1);
						m_last_q  <= 1'b0;
						status_q  <= ctrwr_pkg::ST_OK;
						{alpha_q, blue_q, green_q, red_q} <= '0;
					end
				end
				ctrwr_pkg::S_RAMP_INIT: begin
					i_q     <= ramp_lo;
					limit_q <= XW'(start_q);
					side_q  <= 1'b0;
				end
				ctrwr_pkg::S_RAMP_CHECK: begin
					if ((i_q >= limit_q) && !side_q) begin
						i_q     <= XW'(end_q);
						limit_q <= ramp_hi;
						side_q  <= 1'b1;
					end
				end
				ctrwr_pkg::S_RAMP_WAIT: begin
					k_q <= k_x[9:0];
					c_q <= 2'd0;
				end
				ctrwr_pkg::S_MUL1: begin
					acc_q <= NW'(width_q - k_q) * NW'(op_a);
				end
				ctrwr_pkg::S_MUL2: begin
					acc_q <= acc_q + NW'(k_q) * NW'(op_b) + NW'(width_q >> 1);
					den_q <= NW'(width_q) << (CB - 1);
					dc_q  <= DCW'(CB - 1);
				end
				ctrwr_pkg::S_DIV: begin
					if (div_ge) acc_q <= acc_q - den_q;
					den_q <= den_q >> 1;
					quo_q <= {quo_q[CB-2:0], div_bit};
					dc_q  <= dc_q - DCW'(1);
					if (dc_q == '0) begin
						new_q[c_q] <= {quo_q[CB-2:0], div_bit};
						c_q        <= c_q + 2'd1;
					end
				end
				ctrwr_pkg::S_RAMP_WR: begin
					i_q <= i_q + XW'(1);
				end
				ctrwr_pkg::S_FINISH: begin
					m_last_q  <= 1'b1;
					status_q  <= ctrwr_pkg::ST_OK;
					{alpha_q, blue_q, green_q, red_q} <= '0;
				end
				default: begin
					i_q <= i_q;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {6'b0, alpha_q, blue_q, green_q, red_q, status_q};

endmodule
